[sv/tcw_pkg.sv]
// ============================================================================
// tcw_pkg
// shared types and fixed field widths of the text console writer
// ============================================================================
package tcw_pkg;

    localparam int CMD_W   = 2;
    localparam int CHAR_W  = 8;
    localparam int IDX_W   = 11;
    localparam int CELL_W  = 16;
    localparam int COLOR_W = 4;
    localparam int ATTR_W  = 2 * COLOR_W;

    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
    localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'h20;

    // blank cell after reset: space, light gray on black
    localparam logic [CELL_W-1:0] RESET_CELL   = 16'h0720;
    localparam logic [COLOR_W-1:0] RESET_FOREGROUND = 4'h7;
    localparam logic [COLOR_W-1:0] RESET_BACKGROUND = 4'h0;

    typedef enum logic [CMD_W-1:0] {
        CMD_PRINT = 2'd0,
        CMD_READ  = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    localparam int CFG_INDEX_W = 1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_FOREGROUND = 1'b0,
        CFG_BACKGROUND = 1'b1
    } cfg_reg_t;

    // cursor update requests from the controller
    typedef struct packed {
        logic home;
        logic next_line;
        logic advance;
    } cursor_op_t;

endpackage

[sv/tcw_ram.sv]
// ============================================================================
// tcw_ram
// generic simple dual-port ram, one write port, one registered read port
// ============================================================================
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[sv/tcw_cursor.sv]
// ============================================================================
// tcw_cursor
// cursor row, column and row base; gives current and next linear index
// ============================================================================
module tcw_cursor
    import tcw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  cursor_op_t                           op,
    output logic                                 last_row,
    output logic                                 wrap_due,
    output logic [$clog2(ROWS*COLUMNS+1)-1:0]    cur_index,
    output logic [$clog2(ROWS*COLUMNS+1)-1:0]    next_index
);

    localparam int IW = $clog2(ROWS * COLUMNS + 1);
    localparam int CW = $clog2(COLUMNS + 1);
    localparam int RW = $clog2(ROWS);

    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic [IW-1:0] base_reg, base_next;

    assign last_row = (row_reg == RW'(ROWS - 1));
    assign wrap_due = (col_reg >= CW'(COLUMNS));

    always_comb
    begin
        col_next  = col_reg;
        row_next  = row_reg;
        base_next = base_reg;
        priority if (op.home)
        begin
            col_next  = '0;
            row_next  = '0;
            base_next = '0;
        end
        else if (op.next_line)
        begin
            col_next = '0;
            if (!last_row)
            begin
                row_next  = row_reg + RW'(1);
                base_next = base_reg + IW'(COLUMNS);
            end
        end
        else if (op.advance)
        begin
            col_next = col_reg + CW'(1);
        end
    end

    assign cur_index  = base_reg + IW'(col_reg);
    assign next_index = base_next + IW'(col_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            base_reg <= '0;
        end
        else
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            base_reg <= base_next;
        end
    end

endmodule

[sv/tcw_ctrl.sv]
// ============================================================================
// tcw_ctrl
// command sequencer: print, read, clear, scroll copy and blank fill sweeps
// ============================================================================
module tcw_ctrl
    import tcw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic [CMD_W-1:0]                     command,
    input  logic [CHAR_W-1:0]                    char_code,
    input  logic [IDX_W-1:0]                     cell_index,
    input  logic [ATTR_W-1:0]                    attr,
    output logic                                 busy,
    output logic                                 done,
    output logic [IDX_W-1:0]                     cursor_index,
    output logic [CELL_W-1:0]                    cell_value,
    output logic                                 scrolled,
    // cursor
    output cursor_op_t                           cur_op,
    input  logic                                 last_row,
    input  logic                                 wrap_due,
    input  logic [$clog2(ROWS*COLUMNS+1)-1:0]    cur_index,
    input  logic [$clog2(ROWS*COLUMNS+1)-1:0]    next_index,
    // screen memory
    output logic                                 mem_we,
    output logic [$clog2(ROWS*COLUMNS)-1:0]      mem_waddr,
    output logic [CELL_W-1:0]                    mem_wdata,
    output logic [$clog2(ROWS*COLUMNS)-1:0]      mem_raddr,
    input  logic [CELL_W-1:0]                    mem_rdata
);

    localparam int CELL_COUNT = ROWS * COLUMNS;
    localparam int AW  = $clog2(CELL_COUNT);
    localparam int AW1 = $clog2(CELL_COUNT + 1);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_COPY   = 5'b00010,
        ST_FILL   = 5'b00100,
        ST_PLACE  = 5'b01000,
        ST_FINISH = 5'b10000
    } state_t;

    state_t              state_reg, state_next;
    state_t              resume_reg, resume_next;
    logic [AW1-1:0]      scan_reg, scan_next;
    logic                pend_reg, pend_next;
    logic [CELL_W-1:0]   blank_reg, blank_next;
    logic [CHAR_W-1:0]   char_reg, char_next;
    logic                read_hit_reg, read_hit_next;
    logic                scroll_reg, scroll_next;
    logic                done_reg, done_next;
    logic [IDX_W-1:0]    cursor_index_reg, cursor_index_next;
    logic [CELL_W-1:0]   cell_value_reg, cell_value_next;
    logic                scrolled_reg, scrolled_next;
    logic [AW1-1:0]      copy_dst;

    assign copy_dst = scan_reg - AW1'(COLUMNS + 1);

    always_comb
    begin
        state_next        = state_reg;
        resume_next       = resume_reg;
        scan_next         = scan_reg;
        pend_next         = pend_reg;
        blank_next        = blank_reg;
        char_next         = char_reg;
        read_hit_next     = read_hit_reg;
        scroll_next       = scroll_reg;
        done_next         = 1'b0;
        cursor_index_next = cursor_index_reg;
        cell_value_next   = cell_value_reg;
        scrolled_next     = scrolled_reg;
        cur_op            = '0;
        mem_we            = 1'b0;
        mem_waddr         = scan_reg[AW-1:0];
        mem_wdata         = blank_reg;
        mem_raddr         = AW'(cell_index);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    char_next     = char_code;
                    blank_next    = {attr, SPACE_CODE};
                    scroll_next   = 1'b0;
                    read_hit_next = (cmd_t'(command) == CMD_READ) &&
                                    (32'(cell_index) < CELL_COUNT);
                    state_next    = ST_FINISH;
                    unique case (cmd_t'(command))
                        CMD_PRINT:
                        begin
                            if (char_code != NEWLINE_CODE)
                            begin
                                state_next = ST_PLACE;
                            end
                            if (char_code == NEWLINE_CODE || wrap_due)
                            begin
                                cur_op.next_line = 1'b1;
                                if (last_row)
                                begin
                                    // scroll first, then finish the print
                                    resume_next = state_next;
                                    state_next  = ST_COPY;
                                    scan_next   = AW1'(COLUMNS);
                                    pend_next   = 1'b0;
                                    scroll_next = 1'b1;
                                end
                            end
                        end
                        CMD_READ:
                        begin
                            // read issued now, data lands in the finish cycle
                            state_next = ST_FINISH;
                        end
                        CMD_CLEAR:
                        begin
                            cur_op.home = 1'b1;
                            scan_next   = '0;
                            resume_next = ST_FINISH;
                            state_next  = ST_FILL;
                        end
                        CMD_NOP:
                        begin
                            state_next = ST_FINISH;
                        end
                    endcase
                end
            end
            ST_COPY:
            begin
                // read one row below, write back the cell read last cycle
                if (pend_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = copy_dst[AW-1:0];
                    mem_wdata = mem_rdata;
                end
                if (scan_reg != AW1'(CELL_COUNT))
                begin
                    mem_raddr = scan_reg[AW-1:0];
                    scan_next = scan_reg + AW1'(1);
                    pend_next = 1'b1;
                end
                else
                begin
                    scan_next  = AW1'(CELL_COUNT - COLUMNS);
                    pend_next  = 1'b0;
                    state_next = ST_FILL;
                end
            end
            ST_FILL:
            begin
                mem_we = 1'b1;
                if (scan_reg == AW1'(CELL_COUNT - 1))
                begin
                    state_next = resume_reg;
                end
                else
                begin
                    scan_next = scan_reg + AW1'(1);
                end
            end
            ST_PLACE:
            begin
                mem_we            = 1'b1;
                mem_waddr         = cur_index[AW-1:0];
                mem_wdata         = {blank_reg[CELL_W-1:CHAR_W], char_reg};
                cur_op.advance    = 1'b1;
                done_next         = 1'b1;
                cursor_index_next = IDX_W'(next_index);
                cell_value_next   = '0;
                scrolled_next     = scroll_reg;
                state_next        = ST_IDLE;
            end
            ST_FINISH:
            begin
                done_next         = 1'b1;
                cursor_index_next = IDX_W'(next_index);
                cell_value_next   = read_hit_reg ? mem_rdata : '0;
                scrolled_next     = scroll_reg;
                state_next        = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            // reset sweep blanks the whole screen before the first command
            state_reg    <= ST_FILL;
            resume_reg   <= ST_IDLE;
            scan_reg     <= '0;
            pend_reg     <= 1'b0;
            blank_reg    <= RESET_CELL;
            read_hit_reg <= 1'b0;
            scroll_reg   <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            resume_reg   <= resume_next;
            scan_reg     <= scan_next;
            pend_reg     <= pend_next;
            blank_reg    <= blank_next;
            read_hit_reg <= read_hit_next;
            scroll_reg   <= scroll_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg         <= char_next;
        cursor_index_reg <= cursor_index_next;
        cell_value_reg   <= cell_value_next;
        scrolled_reg     <= scrolled_next;
    end

    assign busy         = (state_reg != ST_IDLE);
    assign done         = done_reg;
    assign cursor_index = cursor_index_reg;
    assign cell_value   = cell_value_reg;
    assign scrolled     = scrolled_reg;

endmodule

[sv/text_console_writer_top.sv]
// ============================================================================
// text_console_writer_top
// character-cell text console: screen memory, cursor and print/read/clear
// ============================================================================
//
// usage
// - a command transfer happens at a rising edge with start high and busy low;
//   command, char_code and cell_index are sampled at that edge
// - each command gives exactly one result: done is high for one cycle and
//   cursor_index, cell_value and scrolled hold the result in that cycle
// - the receiver cannot stall; results must be taken when done is high
// - print of a plain character, newline without scroll, read and the
//   unused command: the block passes through the PLACE or FINISH state,
//   then raises done as it returns to idle, ready for the next command
// - scroll (newline or wrap on the last row): the copy sweep moves one cell
//   per cycle through the single read and write port of the screen ram,
//   then blanks the last row
// - clear: one blank write per cycle over every screen cell
// - after reset the block is busy while it writes a blank cell (space,
//   color 0x07) to every screen location
// - color registers are written through cfg_write/cfg_index/cfg_data at
//   any time, also during the reset sweep; they take effect on the next
//   command
//
module text_console_writer_top
    import tcw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                   clk,
    input  logic                   rst_n,
    // command channel
    input  logic                   start,
    output logic                   busy,
    input  logic [CMD_W-1:0]       command,
    input  logic [CHAR_W-1:0]      char_code,
    input  logic [IDX_W-1:0]       cell_index,
    // result channel
    output logic                   done,
    output logic [IDX_W-1:0]       cursor_index,
    output logic [CELL_W-1:0]      cell_value,
    output logic                   scrolled,
    // color register writes
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [COLOR_W-1:0]     cfg_data
);

    localparam int CELL_COUNT = ROWS * COLUMNS;
    localparam int AW = $clog2(CELL_COUNT);
    localparam int IW = $clog2(CELL_COUNT + 1);

    // color registers, background sits in the upper attribute nibble
    logic [COLOR_W-1:0] foreground_reg, foreground_next;
    logic [COLOR_W-1:0] background_reg, background_next;
    logic [ATTR_W-1:0]  attr;

    always_comb
    begin
        foreground_next = foreground_reg;
        background_next = background_reg;
        if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_FOREGROUND: foreground_next = cfg_data;
                CFG_BACKGROUND: background_next = cfg_data;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            foreground_reg <= RESET_FOREGROUND;
            background_reg <= RESET_BACKGROUND;
        end
        else
        begin
            foreground_reg <= foreground_next;
            background_reg <= background_next;
        end
    end

    assign attr = {background_reg, foreground_reg};

    // cursor tracking
    cursor_op_t      cur_op;
    logic            last_row;
    logic            wrap_due;
    logic [IW-1:0]   cur_index;
    logic [IW-1:0]   next_index;

    // screen ram port
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [CELL_W-1:0] mem_wdata;
    logic [AW-1:0]     mem_raddr;
    logic [CELL_W-1:0] mem_rdata;

    tcw_cursor #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_cursor (
        .clk        (clk),
        .rst_n      (rst_n),
        .op         (cur_op),
        .last_row   (last_row),
        .wrap_due   (wrap_due),
        .cur_index  (cur_index),
        .next_index (next_index)
    );

    // the copy sweep only reads ahead of its writes, so the ram needs no
    // forwarding; a read right after a print sees the finished write
    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELL_COUNT)
    ) u_screen_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    tcw_ctrl #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .command      (command),
        .char_code    (char_code),
        .cell_index   (cell_index),
        .attr         (attr),
        .busy         (busy),
        .done         (done),
        .cursor_index (cursor_index),
        .cell_value   (cell_value),
        .scrolled     (scrolled),
        .cur_op       (cur_op),
        .last_row     (last_row),
        .wrap_due     (wrap_due),
        .cur_index    (cur_index),
        .next_index   (next_index),
        .mem_we       (mem_we),
        .mem_waddr    (mem_waddr),
        .mem_wdata    (mem_wdata),
        .mem_raddr    (mem_raddr),
        .mem_rdata    (mem_rdata)
    );

endmodule

[sv/tcw_checker.sv]
// ============================================================================
// tcw_checker
// port-level checks of the command and result channels
// ============================================================================
module tcw_checker
    import tcw_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              done,
    input logic              scrolled,
    input logic [CELL_W-1:0] cell_value
);

    // an accepted command is followed by busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("command transfer not followed by busy");

    // a result only comes out of a busy period
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without preceding busy");

    // one result per command, never two strobes in a row
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    // a scroll comes only from a print, which returns no cell data
    a_scroll_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        (done && scrolled) |-> (cell_value == '0))
        else $error("scrolled result carries cell data");

endmodule

bind text_console_writer_top tcw_checker u_tcw_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .done       (done),
    .scrolled   (scrolled),
    .cell_value (cell_value)
);

[dv/tb_top.sv]
// ============================================================================
// tb_top
// self-checking bench for the text console writer: print, read, clear and
// the unused command are driven through the start/busy port with random
// gaps, every done strobe is checked against a cycle-free model of the
// screen, cursor and color registers, and colors change between phases
// ============================================================================
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import tcw_pkg::*;

    localparam int SCREEN_COLS    = 80;
    localparam int SCREEN_ROWS    = 25;
    localparam int CELLS          = SCREEN_COLS * SCREEN_ROWS;
    localparam int IDX_MAX        = (1 << IDX_W) - 1;
    localparam int RANDOM_ITEMS   = 1750;
    localparam int PHASE_ITEMS    = 250;
    // a scroll or clear sweeps every cell, so allow several sweeps of silence
    localparam int WATCHDOG_LIMIT = 10 * CELLS;
    localparam int DRAIN_CYCLES   = CELLS + 100;

    typedef enum logic {
        SLOT_COMMAND,
        SLOT_REG_WRITE
    } slot_kind_t;

    // one entry of the stimulus list: a command transfer or a color write
    typedef struct packed {
        slot_kind_t          kind;
        cmd_t                cmd;
        logic [CHAR_W-1:0]   ch;
        logic [IDX_W-1:0]    idx;
        logic [2:0]          gap;
        cfg_reg_t            reg_sel;
        logic [COLOR_W-1:0]  reg_val;
    } console_slot_t;

    // what the block should report for one command
    typedef struct packed {
        logic [IDX_W-1:0]  cursor;
        logic [CELL_W-1:0] cell_word;
        logic              scrolled;
    } console_report_t;

    // dut ports, all inputs known from time zero
    logic                   clk;
    logic                   rst_n = 1'b0;
    logic                   start = 1'b0;
    logic                   busy;
    logic [CMD_W-1:0]       command = '0;
    logic [CHAR_W-1:0]      char_code = '0;
    logic [IDX_W-1:0]       cell_index = '0;
    logic                   done;
    logic [IDX_W-1:0]       cursor_index;
    logic [CELL_W-1:0]      cell_value;
    logic                   scrolled;
    logic                   cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [COLOR_W-1:0]     cfg_data = '0;

    // stimulus list and outstanding reports
    console_slot_t   pending_q[$];
    console_report_t report_q[$];

    // screen model
    logic [CELL_W-1:0]  screen_model [CELLS];
    int unsigned        model_row = 0;
    int unsigned        model_col = 0;
    logic [COLOR_W-1:0] model_fg = RESET_FOREGROUND;
    logic [COLOR_W-1:0] model_bg = RESET_BACKGROUND;

    // bookkeeping
    int unsigned gap_left = 0;
    int unsigned quiet_cycles = 0;
    int unsigned mismatch_count = 0;
    int unsigned result_count = 0;
    int unsigned scroll_count = 0;
    int unsigned reg_write_count = 0;
    int unsigned queued_items = 0;
    int unsigned cmd_count [4] = '{default: 0};
    bit          burst_mode = 1'b0;

    text_console_writer_top #(
        .COLUMNS (SCREEN_COLS),
        .ROWS    (SCREEN_ROWS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .command      (command),
        .char_code    (char_code),
        .cell_index   (cell_index),
        .done         (done),
        .cursor_index (cursor_index),
        .cell_value   (cell_value),
        .scrolled     (scrolled),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // 8 ns clock
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // ------------------------------------------------------------------------
    // screen model
    // ------------------------------------------------------------------------

    // cell with the current color attribute, background in the upper nibble
    function automatic logic [CELL_W-1:0] colored_cell(input logic [CHAR_W-1:0] ch);
        return {model_bg, model_fg, ch};
    endfunction

    function automatic void blank_screen();
        for (int i = 0; i < CELLS; i++)
        begin
            screen_model[i] = colored_cell(SPACE_CODE);
        end
    endfunction

    // column 0 of the next row, scrolling up one row when already at the bottom
    function automatic bit advance_line();
        model_col = 0;
        if (model_row >= SCREEN_ROWS - 1)
        begin
            model_row = SCREEN_ROWS - 1;
            for (int i = 0; i + SCREEN_COLS < CELLS; i++)
            begin
                screen_model[i] = screen_model[i + SCREEN_COLS];
            end
            for (int i = CELLS - SCREEN_COLS; i < CELLS; i++)
            begin
                screen_model[i] = colored_cell(SPACE_CODE);
            end
            return 1'b1;
        end
        model_row++;
        return 1'b0;
    endfunction

    function automatic console_report_t apply_console_command(
        input cmd_t              cmd,
        input logic [CHAR_W-1:0] ch,
        input logic [IDX_W-1:0]  idx
    );
        console_report_t rep;
        rep = '0;
        case (cmd)
            CMD_PRINT:
            begin
                if (ch == NEWLINE_CODE)
                begin
                    rep.scrolled = advance_line();
                end
                else
                begin
                    // deferred wrap: a full row moves on only when the next
                    // printable character arrives
                    if (model_col >= SCREEN_COLS)
                    begin
                        rep.scrolled = advance_line();
                    end
                    screen_model[model_row * SCREEN_COLS + model_col] = colored_cell(ch);
                    model_col++;
                end
            end
            CMD_READ:
            begin
                // out-of-range reads give zero
                if (idx < CELLS)
                begin
                    rep.cell_word = screen_model[idx];
                end
            end
            CMD_CLEAR:
            begin
                blank_screen();
                model_row = 0;
                model_col = 0;
            end
            default:
            begin
                // unused command only reports the cursor
            end
        endcase
        rep.cursor = IDX_W'(model_row * SCREEN_COLS + model_col);
        return rep;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus list builders
    // ------------------------------------------------------------------------

    task automatic queue_command(
        input cmd_t              cmd,
        input logic [CHAR_W-1:0] ch,
        input logic [IDX_W-1:0]  idx
    );
        console_slot_t slot;
        slot         = '0;
        slot.kind    = SLOT_COMMAND;
        slot.cmd     = cmd;
        slot.ch      = ch;
        slot.idx     = idx;
        // idle cycles after this transfer; none inside a burst
        slot.gap     = burst_mode ? 3'd0 : 3'($urandom_range(0, 7));
        pending_q.push_back(slot);
        queued_items++;
    endtask

    // a color write waits in the driver until the block has drained
    task automatic queue_reg_write(input cfg_reg_t sel, input logic [COLOR_W-1:0] val);
        console_slot_t slot;
        slot         = '0;
        slot.kind    = SLOT_REG_WRITE;
        slot.reg_sel = sel;
        slot.reg_val = val;
        pending_q.push_back(slot);
    endtask

    task automatic queue_text_line(input int unsigned len, input bit end_line);
        logic [CHAR_W-1:0] ch;
        for (int unsigned i = 0; i < len; i++)
        begin
            do
                ch = CHAR_W'($urandom_range(0, 255));
            while (ch == NEWLINE_CODE);
            queue_command(CMD_PRINT, ch, IDX_W'($urandom_range(0, IDX_MAX)));
        end
        if (end_line)
        begin
            queue_command(CMD_PRINT, NEWLINE_CODE, IDX_W'($urandom_range(0, IDX_MAX)));
        end
    endtask

    task automatic queue_read_burst(input int unsigned count);
        logic [IDX_W-1:0] idx;
        for (int unsigned i = 0; i < count; i++)
        begin
            case ($urandom_range(0, 9))
                0:       idx = IDX_W'($urandom_range(CELLS, IDX_MAX));
                1, 2:    idx = IDX_W'($urandom_range(CELLS - SCREEN_COLS, CELLS - 1));
                default: idx = IDX_W'($urandom_range(0, CELLS - 1));
            endcase
            queue_command(CMD_READ, CHAR_W'($urandom_range(0, 255)), idx);
        end
    endtask

    // one printed line per mismatch, every one counted
    task automatic log_mismatch(input string what);
        mismatch_count++;
        $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    // ------------------------------------------------------------------------
    // driver: launches transfers from the list, holds start until busy is low
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : driver
        console_slot_t head;
        logic          next_start;
        logic          next_write;
        if (rst_n)
        begin
            next_start = start;
            next_write = 1'b0;
            // transfer at this edge: predict its report right away
            if (start && !busy)
            begin
                report_q.push_back(apply_console_command(cmd_t'(command), char_code,
                                                         cell_index));
                cmd_count[command]++;
                next_start = 1'b0;
            end
            if (!next_start)
            begin
                if (gap_left != 0)
                begin
                    gap_left--;
                end
                else if (pending_q.size() != 0)
                begin
                    head = pending_q[0];
                    if (head.kind == SLOT_COMMAND)
                    begin
                        void'(pending_q.pop_front());
                        command    <= head.cmd;
                        char_code  <= head.ch;
                        cell_index <= head.idx;
                        gap_left   = head.gap;
                        next_start = 1'b1;
                    end
                    else if (!start && !busy && report_q.size() == 0)
                    begin
                        // block idle and every report in: safe to recolor
                        void'(pending_q.pop_front());
                        cfg_index  <= head.reg_sel;
                        cfg_data   <= head.reg_val;
                        next_write = 1'b1;
                        if (head.reg_sel == CFG_FOREGROUND)
                        begin
                            model_fg = head.reg_val;
                        end
                        else
                        begin
                            model_bg = head.reg_val;
                        end
                        reg_write_count++;
                    end
                end
            end
            start     <= next_start;
            cfg_write <= next_write;
        end
    end

    // ------------------------------------------------------------------------
    // monitor: checks each done strobe against the oldest outstanding report
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        console_report_t want;
        if (rst_n)
        begin
            // watchdog sees a transfer or a result as progress
            if ((start && !busy) || done)
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
            if (done)
            begin
                if (report_q.size() == 0)
                begin
                    log_mismatch($sformatf(
                        "result with nothing outstanding: cursor %0d cell %h scrolled %b",
                        cursor_index, cell_value, scrolled));
                end
                else
                begin
                    want = report_q.pop_front();
                    result_count++;
                    if (want.scrolled)
                    begin
                        scroll_count++;
                    end
                    if (cursor_index !== want.cursor)
                    begin
                        log_mismatch($sformatf("result %0d cursor_index %0d, want %0d",
                                               result_count, cursor_index, want.cursor));
                    end
                    if (cell_value !== want.cell_word)
                    begin
                        log_mismatch($sformatf("result %0d cell_value %h, want %h",
                                               result_count, cell_value, want.cell_word));
                    end
                    if (scrolled !== want.scrolled)
                    begin
                        log_mismatch($sformatf("result %0d scrolled %b, want %b",
                                               result_count, scrolled, want.scrolled));
                    end
                end
            end
        end
    end

    // watchdog: nothing moved for too long
    initial
    begin : watchdog
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("[%0t] watchdog: no transfer or result for %0d cycles", $realtime,
                 WATCHDOG_LIMIT);
        $display("text_console_writer_top regression: fail");
        $finish;
    end

    // ------------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        int unsigned directed_items;
        int unsigned phase;
        int unsigned phase_mark;
        int unsigned pick;
        logic [COLOR_W-1:0] fg_val;
        logic [COLOR_W-1:0] bg_val;

        // model starts from the reset sweep: space, color 0x07
        blank_screen();

        // first colors, written once the reset sweep is over
        queue_reg_write(CFG_FOREGROUND, 4'hF);
        queue_reg_write(CFG_BACKGROUND, 4'hF);

        // directed: reset contents, read range edges, unused command,
        // character extremes, newline, clear with the new colors
        queue_command(CMD_READ, 8'h00, IDX_W'(0));
        queue_command(CMD_READ, 8'hFF, IDX_W'(CELLS - 1));
        queue_command(CMD_READ, 8'h00, IDX_W'(CELLS));
        queue_command(CMD_READ, 8'hFF, IDX_W'(IDX_MAX));
        queue_command(CMD_NOP, 8'hFF, IDX_W'(IDX_MAX));
        queue_command(CMD_PRINT, 8'h00, IDX_W'(0));
        queue_command(CMD_PRINT, 8'hFF, IDX_W'(IDX_MAX));
        queue_command(CMD_PRINT, 8'h41, IDX_W'(0));
        queue_command(CMD_READ, 8'h00, IDX_W'(0));
        queue_command(CMD_READ, 8'h00, IDX_W'(1));
        queue_command(CMD_READ, 8'h00, IDX_W'(2));
        queue_command(CMD_PRINT, NEWLINE_CODE, IDX_W'(0));
        queue_command(CMD_PRINT, NEWLINE_CODE, IDX_W'(0));
        queue_command(CMD_READ, 8'h00, IDX_W'(SCREEN_COLS));
        queue_command(CMD_NOP, 8'h00, IDX_W'(0));
        queue_command(CMD_CLEAR, 8'h00, IDX_W'(0));
        queue_command(CMD_READ, 8'h00, IDX_W'(0));
        queue_command(CMD_READ, 8'h00, IDX_W'(CELLS - 1));
        directed_items = queued_items;

        // opening shape: fill a row to hit the deferred wrap, walk to the
        // bottom, fill the last row so the cursor sits past the last cell,
        // then wrap and newline there to scroll both ways
        queue_text_line(SCREEN_COLS + 1, 1'b0);
        for (int i = 0; i < SCREEN_ROWS - 2; i++)
        begin
            queue_command(CMD_PRINT, NEWLINE_CODE, IDX_W'($urandom_range(0, IDX_MAX)));
        end
        queue_text_line(SCREEN_COLS, 1'b0);
        queue_read_burst(3);
        queue_text_line(1, 1'b1);
        queue_read_burst(4);

        // random sequences in phases, colors change between phases
        phase      = 0;
        phase_mark = queued_items;
        while (queued_items < directed_items + RANDOM_ITEMS)
        begin
            if (queued_items >= phase_mark)
            begin
                // extremes first, then random colors
                case (phase)
                    0:       begin fg_val = 4'hF; bg_val = 4'h0; end
                    1:       begin fg_val = 4'h0; bg_val = 4'hF; end
                    2:       begin fg_val = 4'h0; bg_val = 4'h0; end
                    3:       begin fg_val = 4'hF; bg_val = 4'hF; end
                    default:
                    begin
                        fg_val = COLOR_W'($urandom_range(0, 15));
                        bg_val = COLOR_W'($urandom_range(0, 15));
                    end
                endcase
                queue_reg_write(CFG_FOREGROUND, fg_val);
                queue_reg_write(CFG_BACKGROUND, bg_val);
                phase++;
                phase_mark += PHASE_ITEMS;
            end
            burst_mode = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 45)
            begin
                // text line, some longer than a row
                queue_text_line($urandom_range(1, SCREEN_COLS + 20), $urandom_range(0, 9) < 7);
            end
            else if (pick < 58)
            begin
                // run of empty lines
                for (int unsigned i = $urandom_range(1, 6); i != 0; i--)
                begin
                    queue_command(CMD_PRINT, NEWLINE_CODE, IDX_W'($urandom_range(0, IDX_MAX)));
                end
            end
            else if (pick < 78)
            begin
                queue_read_burst($urandom_range(1, 6));
            end
            else if (pick < 81)
            begin
                queue_command(CMD_CLEAR, CHAR_W'($urandom_range(0, 255)),
                              IDX_W'($urandom_range(0, IDX_MAX)));
            end
            else
            begin
                // noise: any field value, no clears so the cursor gets deep
                for (int unsigned i = $urandom_range(1, 4); i != 0; i--)
                begin
                    case ($urandom_range(0, 2))
                        0:       queue_command(CMD_PRINT, CHAR_W'($urandom_range(0, 255)),
                                               IDX_W'($urandom_range(0, IDX_MAX)));
                        1:       queue_command(CMD_READ, CHAR_W'($urandom_range(0, 255)),
                                               IDX_W'($urandom_range(0, IDX_MAX)));
                        default: queue_command(CMD_NOP, CHAR_W'($urandom_range(0, 255)),
                                               IDX_W'($urandom_range(0, IDX_MAX)));
                    endcase
                end
            end
        end

        // single reset, released on a clock edge
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // wait for the list to empty and every report to arrive
        while (pending_q.size() != 0 || start || report_q.size() != 0)
        begin
            @(posedge clk);
        end
        // a full sweep of quiet time to catch a stray strobe
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (report_q.size() != 0)
        begin
            log_mismatch($sformatf("%0d reports never arrived", report_q.size()));
        end

        $display("covered %0d commands: %0d prints, %0d reads, %0d clears, %0d unused",
                 result_count, cmd_count[CMD_PRINT], cmd_count[CMD_READ],
                 cmd_count[CMD_CLEAR], cmd_count[CMD_NOP]);
        $display("%0d scrolls, %0d color register writes over %0d phases, %0d mismatches",
                 scroll_count, reg_write_count, phase, mismatch_count);
        if (mismatch_count == 0)
        begin
            $display("text_console_writer_top regression: pass");
        end
        else
        begin
            $display("text_console_writer_top regression: fail");
        end
        $finish;
    end

endmodule
